>>> rtl/jsv_pkg.sv
// Shared types, codes and character helpers for the JSON scalar validator.
// No dependencies; imported by every module of the block.
package jsv_pkg;

    // Parse phases, one-hot
    typedef enum logic [10:0] {
        PH_LEAD  = 11'b000_0000_0001,
        PH_LIT   = 11'b000_0000_0010,
        PH_SIGN  = 11'b000_0000_0100,
        PH_ZERO  = 11'b000_0000_1000,
        PH_INT   = 11'b000_0001_0000,
        PH_DOT   = 11'b000_0010_0000,
        PH_FRAC  = 11'b000_0100_0000,
        PH_EXPE  = 11'b000_1000_0000,
        PH_ESIGN = 11'b001_0000_0000,
        PH_EXP   = 11'b010_0000_0000,
        PH_TRAIL = 11'b100_0000_0000
    } phase_t;

    // Verdict status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EXPECT  = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_ROOT    = 2'd3;

    // Value kinds
    localparam logic [1:0] KIND_NULL   = 2'd0;
    localparam logic [1:0] KIND_FALSE  = 2'd1;
    localparam logic [1:0] KIND_TRUE   = 2'd2;
    localparam logic [1:0] KIND_NUMBER = 2'd3;

    localparam logic [7:0] CH_NUL = 8'h00;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] value_kind;
    } verdict_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] kind);
        return (kind == KIND_FALSE) ? 3'd5 : 3'd4;
    endfunction

    // Literal text; kind NUMBER folds onto null as in kind mod 3
    function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] pos);
        logic [7:0] c;
        c = CH_NUL;
        case (kind)
            KIND_FALSE: begin
                case (pos)
                    3'd0:    c = "f";
                    3'd1:    c = "a";
                    3'd2:    c = "l";
                    3'd3:    c = "s";
                    3'd4:    c = "e";
                    default: c = CH_NUL;
                endcase
            end
            KIND_TRUE: begin
                case (pos)
                    3'd0:    c = "t";
                    3'd1:    c = "r";
                    3'd2:    c = "u";
                    3'd3:    c = "e";
                    default: c = CH_NUL;
                endcase
            end
            default: begin
                case (pos)
                    3'd0:    c = "n";
                    3'd1:    c = "u";
                    3'd2:    c = "l";
                    3'd3:    c = "l";
                    default: c = CH_NUL;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

>>> rtl/jsv_parse.sv
// Parse state machine of the JSON scalar validator: phase, literal position,
// kind and error registers, stepped once per byte. Depends on jsv_pkg.
module jsv_parse import jsv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] char_byte,
    output verdict_t   verdict
);

    phase_t     phase_reg, phase_next;
    logic [2:0] lit_pos_reg, lit_pos_next;
    logic [1:0] kind_reg, kind_next;
    logic [1:0] err_reg, err_next;

    logic [2:0] lit_pos_inc;
    logic       b_ws, b_dig;

    assign lit_pos_inc = lit_pos_reg + 3'd1;
    assign b_ws        = is_ws(char_byte);
    assign b_dig       = is_digit(char_byte);

    // verdict for a terminator byte
    always_comb begin
        verdict.status     = ST_EXPECT;
        verdict.value_kind = KIND_NULL;
        if (err_reg != ST_OK) begin
            verdict.status = err_reg;
        end else begin
            unique case (phase_reg) inside
                PH_ZERO, PH_INT, PH_FRAC, PH_EXP, PH_TRAIL: begin
                    verdict.status     = ST_OK;
                    verdict.value_kind = kind_reg;
                end
                PH_LIT, PH_SIGN, PH_DOT, PH_EXPE, PH_ESIGN: begin
                    verdict.status = ST_INVALID;
                end
                default: verdict.status = ST_EXPECT;
            endcase
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        lit_pos_next = lit_pos_reg;
        kind_next    = kind_reg;
        err_next     = err_reg;
        if (char_byte == CH_NUL) begin
            phase_next   = PH_LEAD;
            lit_pos_next = 3'd0;
            kind_next    = KIND_NULL;
            err_next     = ST_OK;
        end else if (err_reg == ST_OK) begin
            unique case (phase_reg)
                PH_LIT: begin
                    if (lit_pos_reg < lit_len(kind_reg) &&
                        char_byte == lit_char(kind_reg, lit_pos_reg)) begin
                        lit_pos_next = lit_pos_inc;
                        if (lit_pos_inc >= lit_len(kind_reg)) phase_next = PH_TRAIL;
                    end else begin
                        err_next = ST_INVALID;
                    end
                end
                PH_SIGN: begin
                    if (char_byte == "0")  phase_next = PH_ZERO;
                    else if (b_dig)        phase_next = PH_INT;
                    else                   err_next   = ST_INVALID;
                end
                PH_ZERO, PH_INT: begin
                    if (phase_reg == PH_INT && b_dig) phase_next = PH_INT;
                    else if (char_byte == ".")        phase_next = PH_DOT;
                    else if (char_byte == "e" || char_byte == "E") phase_next = PH_EXPE;
                    else if (b_ws)                    phase_next = PH_TRAIL;
                    else                              err_next   = ST_INVALID;
                end
                PH_DOT: begin
                    if (b_dig) phase_next = PH_FRAC;
                    else       err_next   = ST_INVALID;
                end
                PH_FRAC: begin
                    if (b_dig)                                     phase_next = PH_FRAC;
                    else if (char_byte == "e" || char_byte == "E") phase_next = PH_EXPE;
                    else if (b_ws)                                 phase_next = PH_TRAIL;
                    else                                           err_next   = ST_INVALID;
                end
                PH_EXPE: begin
                    if (char_byte == "+" || char_byte == "-") phase_next = PH_ESIGN;
                    else if (b_dig)                           phase_next = PH_EXP;
                    else                                      err_next   = ST_INVALID;
                end
                PH_ESIGN: begin
                    if (b_dig) phase_next = PH_EXP;
                    else       err_next   = ST_INVALID;
                end
                PH_EXP: begin
                    if (b_dig)     phase_next = PH_EXP;
                    else if (b_ws) phase_next = PH_TRAIL;
                    else           err_next   = ST_INVALID;
                end
                PH_TRAIL: begin
                    if (!b_ws) err_next = ST_ROOT;
                end
                default: begin
                    // leading whitespace; stray codes land here too
                    if (b_ws) begin
                        phase_next = PH_LEAD;
                    end else if (char_byte == "n" || char_byte == "f" ||
                                 char_byte == "t") begin
                        kind_next    = (char_byte == "n") ? KIND_NULL :
                                       (char_byte == "f") ? KIND_FALSE : KIND_TRUE;
                        lit_pos_next = 3'd1;
                        phase_next   = PH_LIT;
                    end else begin
                        kind_next = KIND_NUMBER;
                        if (char_byte == "-")      phase_next = PH_SIGN;
                        else if (char_byte == "0") phase_next = PH_ZERO;
                        else if (b_dig)            phase_next = PH_INT;
                        else begin
                            phase_next = PH_LEAD;
                            err_next   = ST_INVALID;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LEAD;
            lit_pos_reg <= 3'd0;
            kind_reg    <= KIND_NULL;
            err_reg     <= ST_OK;
        end else if (step) begin
            phase_reg   <= phase_next;
            lit_pos_reg <= lit_pos_next;
            kind_reg    <= kind_next;
            err_reg     <= err_next;
        end
    end

endmodule

>>> rtl/json_scalar_validator_top.sv
// Top level of the JSON scalar validator: input beat register, parse state
// machine and verdict register. Depends on jsv_pkg and jsv_parse.
//
// Usage:
//   s_ channel: one byte of JSON text per beat in s_tdata[7:0]. A zero byte
//   ends the text. All other bytes produce no output beat.
//   m_ channel: one verdict beat per terminator byte. m_tdata[1:0] is the
//   status (ok, expect value, invalid value, root not singular) and
//   m_tdata[3:2] the kind (null, false, true, number; zero unless ok).
//   Throughput: one byte per cycle, stepped by the parse state machine,
//   sustained while no terminator waits on a pending verdict (see Stall).
//   Path: a terminator is held in the input beat register, then its
//   verdict is registered in the verdict register, which drives m_tvalid.
//   Reset (aresetn low, synchronous): both beat registers empty, parser back
//   to the leading whitespace phase; s_tready is high straight after.
//   Stall: while a verdict waits on m_tready low, non-terminator bytes keep
//   flowing; a second terminator holds in the input register and s_tready
//   drops until the pending verdict is taken.
//   After each verdict the parser starts afresh on the next byte.
module json_scalar_validator_top import jsv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // input byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    // verdict stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [1:0] status, [3:2] value_kind, [7:4] zero
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    verdict_t   out_verdict_reg;

    verdict_t   verdict;
    logic       in_is_term;
    logic       out_free;
    logic       step;

    assign in_is_term = (in_byte_reg == CH_NUL);
    // verdict register can take a new beat this cycle
    assign out_free   = !out_valid_reg || m_tready;
    // parser consumes the held byte; a terminator needs room for its verdict
    assign step       = in_valid_reg && (!in_is_term || out_free);
    assign s_tready   = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    jsv_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .char_byte (in_byte_reg),
        .verdict   (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= step && in_is_term;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && step && in_is_term) begin
            out_verdict_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_verdict_reg.value_kind, out_verdict_reg.status};

endmodule

>>> rtl/jsv_checker.sv
// Port-level checks for the JSON scalar validator, bound to the top level.
// Depends on jsv_pkg and the json_scalar_validator_top ports.
module jsv_checker import jsv_pkg::*; (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // text beat held by the source while stalled
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("text beat changed while stalled");

    // verdict beat held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("verdict beat changed while stalled");

    // padding bits of a verdict stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:4] == 4'h0)
        else $error("verdict padding not zero");

    // kind is zero on any failing verdict
    a_kind_on_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[3:2] == KIND_NULL)
        else $error("kind reported on failing verdict");

    // reset empties both sides
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not empty after reset");

endmodule

bind json_scalar_validator_top jsv_checker u_jsv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/json_scalar_validator_checker.sv
`timescale 1ns / 1ps
// Verdict checker for the JSON scalar validator: tracks the parse of every accepted
// text byte, queues the verdict each terminator should give and compares verdict beats.
// Depends on jsv_pkg for phase, status and kind codes.
module json_scalar_validator_checker import jsv_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // [1:0] status, [3:2] value_kind
    output int         error_count,
    output int         verdicts_due,
    output int         verdicts_seen
);

    localparam logic [1:0] NO_ERROR = 2'd0;

    phase_t     phase;
    logic [2:0] lit_pos;
    logic [1:0] kind;
    logic [1:0] err;
    verdict_t   due_q[$];
    int         errs;
    int         seen;

    function automatic logic blank_char(input logic [7:0] b);
        return (b == " ") || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
    endfunction

    function automatic logic digit_char(input logic [7:0] b);
        return (b >= "0") && (b <= "9");
    endfunction

    function automatic logic [2:0] literal_len(input logic [1:0] k);
        return (k == KIND_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [7:0] literal_char(input logic [1:0] k, input logic [2:0] pos);
        logic [39:0] txt;
        int          len;
        case (k)
            KIND_FALSE: begin
                txt = "false";
                len = 5;
            end
            KIND_TRUE: begin
                txt = "true";
                len = 4;
            end
            default: begin
                txt = "null";
                len = 4;
            end
        endcase
        return (int'(pos) < len) ? txt[8 * (len - 1 - int'(pos)) +: 8] : CH_NUL;
    endfunction

    task automatic clear_parser();
        phase   = PH_LEAD;
        lit_pos = 3'd0;
        kind    = KIND_NULL;
        err     = NO_ERROR;
    endtask

    // a complete number may go on with '.' (if dot_ok), e/E (if exp_ok) or blanks; anything else is invalid
    task automatic leave_number(input logic [7:0] b, input logic dot_ok, input logic exp_ok);
        if (dot_ok && b == ".")
            phase = PH_DOT;
        else if (exp_ok && (b == "e" || b == "E"))
            phase = PH_EXPE;
        else if (blank_char(b))
            phase = PH_TRAIL;
        else
            err = ST_INVALID;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        verdict_t v;
        if (b == CH_NUL) begin
            v.value_kind = KIND_NULL;
            if (err != NO_ERROR) begin
                v.status = err;
            end else begin
                case (phase)
                    PH_ZERO, PH_INT, PH_FRAC, PH_EXP, PH_TRAIL: begin
                        v.status     = ST_OK;
                        v.value_kind = kind;
                    end
                    PH_LIT, PH_SIGN, PH_DOT, PH_EXPE, PH_ESIGN: v.status = ST_INVALID;
                    default: v.status = ST_EXPECT;
                endcase
            end
            due_q.push_back(v);
            clear_parser();
        end else if (err == NO_ERROR) begin
            case (phase)
                PH_LIT: begin
                    if (lit_pos < literal_len(kind) && b == literal_char(kind, lit_pos)) begin
                        lit_pos = lit_pos + 3'd1;
                        if (lit_pos >= literal_len(kind)) phase = PH_TRAIL;
                    end else begin
                        err = ST_INVALID;
                    end
                end
                PH_SIGN: begin
                    if (b == "0")           phase = PH_ZERO;
                    else if (digit_char(b)) phase = PH_INT;
                    else                    err = ST_INVALID;
                end
                PH_ZERO: leave_number(b, 1'b1, 1'b1);
                PH_INT:  if (!digit_char(b)) leave_number(b, 1'b1, 1'b1);
                PH_DOT: begin
                    if (digit_char(b)) phase = PH_FRAC;
                    else               err = ST_INVALID;
                end
                PH_FRAC: if (!digit_char(b)) leave_number(b, 1'b0, 1'b1);
                PH_EXPE: begin
                    if (b == "+" || b == "-") phase = PH_ESIGN;
                    else if (digit_char(b))   phase = PH_EXP;
                    else                      err = ST_INVALID;
                end
                PH_ESIGN: begin
                    if (digit_char(b)) phase = PH_EXP;
                    else               err = ST_INVALID;
                end
                PH_EXP:   if (!digit_char(b)) leave_number(b, 1'b0, 1'b0);
                PH_TRAIL: if (!blank_char(b)) err = ST_ROOT;
                default: begin
                    if (blank_char(b)) begin
                        phase = PH_LEAD;
                    end else if (b == "n" || b == "f" || b == "t") begin
                        kind    = (b == "n") ? KIND_NULL : (b == "f") ? KIND_FALSE : KIND_TRUE;
                        lit_pos = 3'd1;
                        phase   = PH_LIT;
                    end else begin
                        kind = KIND_NUMBER;
                        if (b == "-")           phase = PH_SIGN;
                        else if (b == "0")      phase = PH_ZERO;
                        else if (digit_char(b)) phase = PH_INT;
                        else                    err = ST_INVALID;
                    end
                end
            endcase
        end
    endtask

    // verdict beat compared first: one accepted at this edge cannot belong
    // to a terminator accepted at the same edge
    always @(posedge aclk) begin : watch
        verdict_t want;
        if (!aresetn) begin
            clear_parser();
            due_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                seen++;
                if (due_q.size() == 0) begin
                    errs++;
                    $error("verdict beat with none due: status %0d, value_kind %0d",
                           m_tdata[1:0], m_tdata[3:2]);
                end else begin
                    want = due_q.pop_front();
                    if (m_tdata[1:0] !== want.status) begin
                        errs++;
                        $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    end
                    if (m_tdata[3:2] !== want.value_kind) begin
                        errs++;
                        $error("value_kind: expected %0d, got %0d",
                               want.value_kind, m_tdata[3:2]);
                    end
                end
            end
            if (s_tvalid && s_tready) parse_byte(s_tdata);
        end
        error_count   <= errs;
        verdicts_due  <= due_q.size();
        verdicts_seen <= seen;
    end

endmodule

>>> sim/json_scalar_validator_top_tb.sv
`timescale 1ns / 1ps
// Top of the JSON scalar validator testbench: clock, reset, text byte stimulus and verdict.
// Depends on jsv_pkg, json_scalar_validator_top and json_scalar_validator_checker.
module json_scalar_validator_top_tb;
    import jsv_pkg::*;

    // generous bound on the length of a legal run
    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_BYTES = 250;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_byte
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;            // [1:0] status, [3:2] value_kind, [7:4] zero

    int fail_count;
    int verdicts_due;
    int verdicts_seen;
    int send_idle;     // percentage of cycles the byte source holds back
    int recv_idle;     // percentage of cycles the verdict sink stalls
    int bytes_sent;
    int cycle_count;

    logic [7:0] text_q[$];   // body of the next text, terminator added on send

    json_scalar_validator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    json_scalar_validator_checker verdict_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .error_count   (fail_count),
        .verdicts_due  (verdicts_due),
        .verdicts_seen (verdicts_seen)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // verdict sink: a fresh ready decision every cycle
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else          m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    // One byte beat. Random holes before it; s_tvalid stays high into the
    // next beat when no hole follows, so it is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Body from text_q, then the zero terminator
    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i]);
        send_byte(CH_NUL);
        text_q.delete();
    endtask

    task automatic append_str(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endtask

    task automatic put_blanks(input int n);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       text_q.push_back(" ");
                1:       text_q.push_back(8'h09);
                2:       text_q.push_back(8'h0A);
                default: text_q.push_back(8'h0D);
            endcase
        end
    endtask

    task automatic put_digits(input int n);
        repeat (n) text_q.push_back(8'("0" + $urandom_range(0, 9)));
    endtask

    // Well-formed number: int part always, sign, fraction, exponent each by chance
    task automatic put_number();
        if ($urandom_range(0, 1)) text_q.push_back("-");
        if ($urandom_range(0, 3) == 0) begin
            text_q.push_back("0");
        end else begin
            text_q.push_back(8'("1" + $urandom_range(0, 8)));
            put_digits($urandom_range(0, 3));
        end
        if ($urandom_range(0, 1)) begin
            text_q.push_back(".");
            put_digits($urandom_range(1, 3));
        end
        if ($urandom_range(0, 1)) begin
            text_q.push_back($urandom_range(0, 1) ? "e" : "E");
            case ($urandom_range(0, 2))
                0:       text_q.push_back("+");
                1:       text_q.push_back("-");
                default: ;
            endcase
            put_digits($urandom_range(1, 2));
        end
    endtask

    // Mostly well-formed scalars with random content; some get cut short,
    // a byte overwritten or junk appended. The rest is raw noise, where any
    // zero byte simply ends a text early.
    task automatic random_text();
        int         pick;
        logic [7:0] dropped;
        if ($urandom_range(0, 99) < 20) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            put_blanks($urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0) begin
                case ($urandom_range(0, 2))
                    0:       append_str("null");
                    1:       append_str("false");
                    default: append_str("true");
                endcase
            end else begin
                put_number();
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(1, 2))
                    if (text_q.size() > 0) dropped = text_q.pop_back();
            end else if (pick == 1) begin
                text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(1, 255));
            end
            put_blanks($urandom_range(0, 2));
            if (pick == 2) text_q.push_back(8'($urandom_range(1, 255)));
        end
    endtask

    // Hold the source off until every due verdict has come back
    task automatic wait_for_verdicts();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (verdicts_due != 0) @(posedge aclk);
    endtask

    task automatic run_phase(input int src_pct, input int sink_pct);
        int start;
        start     = bytes_sent;
        send_idle = src_pct;
        recv_idle = sink_pct;
        while (bytes_sent - start < PHASE_BYTES) begin
            random_text();
            send_text();
        end
        wait_for_verdicts();
    endtask

    initial begin
        send_idle = 20;
        recv_idle = 67;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty text, blanks only, a literal with a trailing blank,
        // a full number with trailing blank, a cut-short literal, junk after
        // a number, a top-bit byte, a second value
        send_text();
        append_str(" \t\n\r");
        send_text();
        append_str("true\t");
        send_text();
        append_str("-0.5e+9 ");
        send_text();
        append_str("nul");
        send_text();
        append_str("0x");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        append_str("1 2");
        send_text();
        wait_for_verdicts();

        run_phase(20, 67);
        run_phase(67, 20);
        run_phase(0, 0);

        repeat (4) @(posedge aclk);
        $display("Summary: %0d text bytes sent, %0d verdicts checked", bytes_sent, verdicts_seen);
        $display("  over source/sink idling of 20/67, 67/20 and none");
        if (fail_count == 0 && verdicts_due == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
rtl/jsv_pkg.sv
rtl/jsv_parse.sv
rtl/json_scalar_validator_top.sv
rtl/jsv_checker.sv
sim/json_scalar_validator_checker.sv
sim/json_scalar_validator_top_tb.sv
